### src/earliest_arrival_job_queue_assert.svh
// ----------------------------------------------------------------------------
// Earliest arrival job queue assertion macros
// Shared forms for the concurrent checks of the job queue.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_ARRIVAL_JOB_QUEUE_ASSERT_SVH
`define EARLIEST_ARRIVAL_JOB_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EAJQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EAJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/eajq_pkg.sv
// ----------------------------------------------------------------------------
// Earliest arrival job queue package
// Command and status codes and the transfer types of the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package eajq_pkg;

    // Command codes.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EXTRACTED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    // One input transfer.
    typedef struct packed {
        logic        command;
        logic [15:0] job_number;
        logic [31:0] arrival_time;
    } eajq_req_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] removed_job;
        logic [31:0] removed_time;
    } eajq_rsp_t;

    // One stored queue entry.
    typedef struct packed {
        logic [15:0] job_number;
        logic [31:0] arrival_time;
    } eajq_entry_t;

endpackage

`default_nettype wire

### src/eajq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module eajq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/earliest_arrival_job_queue.sv
// Insert: the result strobe comes in the cycle after the command transfer.
// Extract: the single read port of the entry RAM first reads every held entry
// for the scan, then reads each entry after the winner once to shift it down;
// the result strobe follows once the shift is done.
// One command is in flight at a time; busy is high during an extract until its result is issued.
// Reset empties the queue; RAM contents are left as they are.
`default_nettype none

`include "earliest_arrival_job_queue_assert.svh"

module earliest_arrival_job_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire eajq_pkg::eajq_req_t request,
    output logic                     done,
    output eajq_pkg::eajq_rsp_t      result
);

    import eajq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = $bits(eajq_entry_t);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    eajq_entry_t      best_reg, best_next;
    eajq_rsp_t        result_reg, result_next;
    logic             done_reg, done_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    eajq_entry_t      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    eajq_entry_t      rd_entry;
    logic             take_new;
    logic [IDX_W-1:0] win_idx;
    eajq_entry_t      win_entry;
    logic             last_scan;
    logic             issue_more;
    logic             accept;

    // Entry storage.
    eajq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scan comparison; ties keep the older entry.
    assign rd_entry   = eajq_entry_t'(ram_rdata);
    assign take_new   = pend_reg &&
                        ((pidx_reg == '0) || (rd_entry.arrival_time < best_reg.arrival_time));
    assign win_idx    = take_new ? pidx_reg : best_idx_reg;
    assign win_entry  = take_new ? rd_entry : best_reg;
    assign last_scan  = pend_reg && (CNT_W'(pidx_reg) == count_reg - 1'b1);
    assign issue_more = issue_reg < count_reg;
    assign accept     = start && (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = '{job_number: request.job_number,
                          arrival_time: request.arrival_time};
        ram_re        = 1'b0;
        ram_raddr     = issue_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.removed_job  = '0;
                    result_next.removed_time = '0;
                    if (request.command == CMD_INSERT)
                    begin
                        done_next = 1'b1;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we             = 1'b1;
                            count_next         = count_reg + 1'b1;
                            result_next.status = STATUS_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next          = 1'b1;
                        result_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        issue_next = '0;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_more)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                if (take_new)
                begin
                    best_idx_next = win_idx;
                    best_next     = win_entry;
                end
                if (last_scan)
                begin
                    state_next = S_SHIFT;
                    issue_next = CNT_W'(win_idx) + 1'b1;
                    pend_next  = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // Read entry i, then write it back at i - 1 once the registered read data arrives.
                if (issue_more)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg - 1'b1;
                    ram_wdata = rd_entry;
                end
                if (!issue_more && !pend_reg)
                begin
                    state_next               = S_IDLE;
                    count_next               = count_reg - 1'b1;
                    done_next                = 1'b1;
                    result_next.status       = STATUS_EXTRACTED;
                    result_next.removed_job  = best_reg.job_number;
                    result_next.removed_time = best_reg.arrival_time;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks on the queue bookkeeping.
    `EAJQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
    `EAJQ_ASSERT_IMPLY(a_full_status, clk, rst_n, done && (result.status == STATUS_FULL), count_reg == CNT_W'(QUEUE_DEPTH), "full reported below depth")
    `EAJQ_ASSERT_IMPLY(a_extract_count, clk, rst_n, done && (result.status == STATUS_EXTRACTED), count_reg + 1'b1 == $past(count_reg), "extract did not remove one entry")
    `EAJQ_ASSERT_NEXT(a_insert_count, clk, rst_n, accept && (request.command == CMD_INSERT) && (count_reg != CNT_W'(QUEUE_DEPTH)), count_reg == $past(count_reg) + 1'b1, "insert did not add one entry")
    `EAJQ_ASSERT_IMPLY(a_idle_write, clk, rst_n, !busy && !start, !ram_we, "RAM write while idle")

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Earliest arrival job queue testbench
// Drives insert and extract commands into the job queue and checks every
// result against a behavioral copy of the queue kept inside the bench.
// A short directed run covers the empty, full and tie cases; random bursts
// then push the fill level up and down under changing sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import eajq_pkg::*;

    localparam int QUEUE_DEPTH    = 8;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int MAX_LATENCY    = 2 * QUEUE_DEPTH + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // One command waiting to be sent, with an optional pause before it.
    typedef struct {
        eajq_req_t req;
        bit        drain_first;
    } job_command_t;

    logic      clk;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    eajq_req_t request = '0;
    logic      busy;
    logic      done;
    eajq_rsp_t result;

    job_command_t job_commands[$];
    eajq_rsp_t    awaited_results[$];

    // Bench copy of the queue contents, oldest entry at index zero.
    eajq_entry_t mirror_entries[QUEUE_DEPTH];
    int unsigned mirror_count = 0;

    int unsigned accepted_cnt = 0;
    int unsigned received_cnt = 0;
    int unsigned total_items  = 0;
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;

    earliest_arrival_job_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one command to the bench copy and return the result it must give.
    function automatic eajq_rsp_t apply_job_command(eajq_req_t req);
        eajq_rsp_t   rsp;
        int unsigned best;
        rsp  = '0;
        best = 0;
        if (req.command == CMD_INSERT)
        begin
            if (mirror_count >= QUEUE_DEPTH)
            begin
                rsp.status = STATUS_FULL;
            end
            else
            begin
                mirror_entries[mirror_count].job_number   = req.job_number;
                mirror_entries[mirror_count].arrival_time = req.arrival_time;
                mirror_count++;
                rsp.status = STATUS_INSERTED;
            end
        end
        else if (mirror_count == 0)
        begin
            rsp.status = STATUS_EMPTY;
        end
        else
        begin
            // Strict compare keeps the oldest entry on equal arrival times.
            for (int unsigned i = 1; i < mirror_count; i++)
            begin
                if (mirror_entries[i].arrival_time < mirror_entries[best].arrival_time)
                    best = i;
            end
            rsp.status       = STATUS_EXTRACTED;
            rsp.removed_job  = mirror_entries[best].job_number;
            rsp.removed_time = mirror_entries[best].arrival_time;
            for (int unsigned i = best + 1; i < mirror_count; i++)
                mirror_entries[i - 1] = mirror_entries[i];
            mirror_count--;
        end
        return rsp;
    endfunction

    task automatic queue_command(logic cmd, logic [15:0] job, logic [31:0] arrival,
                                 bit drain);
        job_command_t item;
        item.req.command      = cmd;
        item.req.job_number   = job;
        item.req.arrival_time = arrival;
        item.drain_first      = drain;
        job_commands.push_back(item);
    endtask

    // Command driver: holds a command until the block takes it, then records
    // the expected result and decides whether to idle or send the next one.
    always @(posedge clk)
    begin : driver
        logic        launch;
        int unsigned idle_pct;
        launch = 1'b0;
        if (accepted_cnt < total_items / 3)
            idle_pct = 16;
        else if (accepted_cnt < 2 * total_items / 3)
            idle_pct = 72;
        else
            idle_pct = 0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                awaited_results.push_back(apply_job_command(request));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (job_commands.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                // A marked command waits until every earlier result is back.
                if (!job_commands[0].drain_first ||
                    (!start && !busy && accepted_cnt == received_cnt))
                    launch = 1'b1;
            end
            if (launch)
            begin
                request <= job_commands[0].req;
                job_commands.pop_front();
            end
            start <= launch;
        end
    end

    // Result monitor: every strobed result is matched against the oldest
    // expectation.
    always @(posedge clk)
    begin : monitor
        eajq_rsp_t want;
        if (rst_n && done)
        begin
            received_cnt <= received_cnt + 1;
            if (awaited_results.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("Unexpected result: status %0d job %h time %h",
                             result.status, result.removed_job, result.removed_time);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.status !== want.status ||
                    result.removed_job !== want.removed_job ||
                    result.removed_time !== want.removed_time)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("Mismatch: expected status %0d job %h time %h, got status %0d job %h time %h",
                                 want.status, want.removed_job, want.removed_time,
                                 result.status, result.removed_job, result.removed_time);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        int unsigned random_count;
        int unsigned burst_len;
        int unsigned insert_pct;
        int unsigned time_mode;
        logic [31:0] arrival;
        logic [15:0] job;
        logic        cmd;

        // Extract on an empty queue, with a busy payload that must be ignored.
        queue_command(CMD_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);

        // Fill the queue with extreme values and repeated arrival times.
        queue_command(CMD_INSERT, 16'hFFFF, 32'd5,          1'b0);
        queue_command(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        queue_command(CMD_INSERT, 16'h8000, 32'd5,          1'b0);
        queue_command(CMD_INSERT, 16'h7FFF, 32'd0,          1'b0);
        queue_command(CMD_INSERT, 16'h0001, 32'd0,          1'b0);
        queue_command(CMD_INSERT, 16'hAAAA, 32'hFFFF_FFFF, 1'b0);
        queue_command(CMD_INSERT, 16'h5555, 32'd7,          1'b0);
        queue_command(CMD_INSERT, 16'h1234, 32'd5,          1'b0);

        // Insert on a full queue must be rejected.
        queue_command(CMD_INSERT, 16'hFFFF, 32'h0000_0000, 1'b0);

        // Drain everything; equal times must come out oldest first.
        queue_command(CMD_EXTRACT, 16'h0000, 32'h0000_0000, 1'b1);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_command(CMD_EXTRACT, 16'($urandom), $urandom, 1'b0);

        // Random bursts with a changing insert bias sweep the fill level.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(30, 4);
            case ($urandom_range(2))
                0:       insert_pct = 15;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            time_mode = $urandom_range(3);
            for (int unsigned k = 0; k < burst_len && random_count < RANDOM_ITEMS; k++)
            begin
                cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
                case (time_mode)
                    0:       arrival = $urandom;
                    1:       arrival = $urandom_range(7);
                    2:       arrival = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    default: arrival = 32'hFFFF_FFF8 + $urandom_range(7);
                endcase
                job = ($urandom_range(9) == 0) ? {16{$urandom_range(1) == 1}}
                                               : 16'($urandom);
                queue_command(cmd, job, arrival, random_count == 0 || $urandom_range(99) == 0);
                random_count++;
            end
        end
        total_items = job_commands.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transfer and its result, then watch for strays.
        while (job_commands.size() != 0 || start || accepted_cnt != received_cnt)
            @(posedge clk);
        repeat (2 * MAX_LATENCY) @(posedge clk);

        if (error_count == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/eajq_pkg.sv
src/eajq_ram.sv
src/earliest_arrival_job_queue.sv
sim/tb_top.sv
